/* src/att_pkg.sv */
// Shared types and constants for the address translation table.
package att_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2
	} att_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_RESP
	} att_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} att_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] action;
		logic       empty;
		logic       match;
		logic       scan_end;
		logic       out_free;
	} att_sts_t;

endpackage

/* src/att_req_if.sv */
// Request channel: valid/ready handshake with the action and both addresses.
interface att_req_if;
	import att_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [ADDR_W-1:0] key_addr;
	logic [ADDR_W-1:0] mapped_addr;

	modport source (output valid, output action, output key_addr, output mapped_addr,
		input ready);
	modport sink (input valid, input action, input key_addr, input mapped_addr,
		output ready);

endinterface

/* src/att_rsp_if.sv */
// Response channel: valid/ready handshake with the lookup and insert results.
interface att_rsp_if;
	import att_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [ADDR_W-1:0] result_addr;
	logic              rejected;
	logic              full_flag;

	modport source (output valid, output found, output result_addr, output rejected,
		output full_flag, input ready);
	modport sink (input valid, input found, input result_addr, input rejected,
		input full_flag, output ready);

endinterface

/* src/att_ctrl.sv */
// Controller state machine that sequences request decode, table scan and response.
module att_ctrl
	import att_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  att_sts_t sts,
	output att_cmd_t cmd
);

	att_state_t state_q;
	att_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				// Only a lookup over a nonempty table needs the scan.
				if (sts.action == ACT_LOOKUP && !sts.empty) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match || sts.scan_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/att_dp.sv */
// Datapath: key and value memories, fill count, sticky flag, scan pointer and result register.
module att_dp
	import att_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  att_cmd_t          cmd,
	output att_sts_t          sts,
	input  logic [1:0]        in_action,
	input  logic [ADDR_W-1:0] in_key_addr,
	input  logic [ADDR_W-1:0] in_mapped_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_found,
	output logic [ADDR_W-1:0] out_result_addr,
	output logic              out_rejected,
	output logic              out_full_flag
);

	logic [ADDR_W-1:0] key_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] val_mem [TABLE_DEPTH];

	logic [1:0]        action_q;
	logic [ADDR_W-1:0] key_q;
	logic [ADDR_W-1:0] val_q;
	logic [CNT_W-1:0]  fill_q;
	logic              flag_q;
	logic [CNT_W-1:0]  idx_q;
	logic              hit_q;
	logic [ADDR_W-1:0] res_q;

	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [ADDR_W-1:0] rd_key_s1;
	logic [ADDR_W-1:0] rd_val_s1;

	logic              out_valid_q;
	logic              out_found_q;
	logic [ADDR_W-1:0] out_result_q;
	logic              out_rejected_q;
	logic              out_flag_q;

	logic              rd_en;
	logic              wr_en;
	logic              match;
	logic              is_lookup;
	logic              is_insert;
	logic              is_clear;
	logic              ins_ok;
	logic              flag_d;

	always_comb begin
		is_lookup = 1'b0;
		is_insert = 1'b0;
		is_clear  = 1'b0;
		case (action_q)
			ACT_LOOKUP: is_lookup = 1'b1;
			ACT_INSERT: is_insert = 1'b1;
			ACT_CLEAR:  is_clear  = 1'b1;
			default:    ;
		endcase
	end

	assign ins_ok = (fill_q < CNT_W'(TABLE_DEPTH)) && (key_q != '0) && (val_q != '0);
	assign wr_en  = cmd.commit && is_insert && ins_ok;
	assign rd_en  = cmd.scan && (idx_q < fill_q);
	assign match  = rd_vld_s1 && (rd_key_s1 == key_q);

	always_comb begin
		flag_d = flag_q;
		if (is_insert && !ins_ok) begin
			flag_d = 1'b1;
		end else if (is_clear) begin
			flag_d = 1'b0;
		end
	end

	always_comb begin
		sts.action   = action_q;
		sts.empty    = (fill_q == '0);
		sts.match    = match;
		sts.scan_end = rd_vld_s1 && rd_last_s1 && !match;
		sts.out_free = !out_valid_q || out_ready;
	end

	// Table memories: one write port at the fill pointer, one registered read at the scan pointer.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[fill_q[IDX_W-1:0]] <= key_q;
			val_mem[fill_q[IDX_W-1:0]] <= val_q;
		end
		if (rd_en) begin
			rd_key_s1 <= key_mem[idx_q[IDX_W-1:0]];
			rd_val_s1 <= val_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			key_q    <= in_key_addr;
			val_q    <= in_mapped_addr;
		end
		if (cmd.scan && match && !hit_q) begin
			res_q <= rd_val_s1;
		end
		if (cmd.commit) begin
			out_found_q    <= is_lookup && hit_q;
			out_result_q   <= (is_lookup && hit_q) ? res_q : '0;
			out_rejected_q <= is_insert && !ins_ok;
			out_flag_q     <= flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			flag_q      <= 1'b0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				hit_q     <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					idx_q      <= idx_q + CNT_W'(1);
					rd_last_s1 <= (idx_q + CNT_W'(1)) == fill_q;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				flag_q <= flag_d;
				if (wr_en) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (is_clear) begin
					fill_q <= '0;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_found       = out_found_q;
	assign out_result_addr = out_result_q;
	assign out_rejected    = out_rejected_q;
	assign out_full_flag   = out_flag_q;

endmodule

/* src/address_translation_table.sv */
// Top level of the address translation table: controller, datapath and checks.
//
// The block keeps an append-only table of (original, converted) address pairs.
// Requests arrive on the req channel, one beat per operation: action 0 looks up
// key_addr, action 1 appends (key_addr, mapped_addr), action 2 clears the table.
// Every request produces exactly one beat on the rsp channel carrying found,
// result_addr, rejected and the sticky full_flag as it stands after the operation.
// An insert with a zero address or into a full table is refused and sets the flag.
// One request is worked on at a time. Insert, clear, the ignored action code and a
// lookup on an empty table pass from dispatch straight to response, with no scan.
// A lookup walks the filled entries through the single read port of the table
// memories at one entry per cycle and stops at the first hit or after the last
// filled entry, so a miss reads every filled entry (up to TABLE_DEPTH of them).
// The next request is accepted as soon as the controller is back in idle after the
// result is loaded; a request that needs no scan passes idle, dispatch and response.
// The result sits in an output register, so a new request is accepted while the
// previous result still waits; a stalled rsp side only holds the next result back.
// Reset empties the table and clears the flag at once; no clearing pass is needed,
// because only entries below the fill count are ever read.
module address_translation_table
	import att_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	att_req_if.sink   req,
	att_rsp_if.source rsp
);

	att_cmd_t cmd;
	att_sts_t sts;
	logic     in_ready;

	assign req.ready = in_ready;

	att_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the table and the result register that drives rsp.
	att_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_action       (req.action),
		.in_key_addr     (req.key_addr),
		.in_mapped_addr  (req.mapped_addr),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_found       (rsp.found),
		.out_result_addr (rsp.result_addr),
		.out_rejected    (rsp.rejected),
		.out_full_flag   (rsp.full_flag)
	);

`ifndef NO_ASSERTIONS
	// After a beat is taken in, no further request is accepted until its result is committed.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// A result is only committed when the output register is free or being drained.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed over an unread result");

	// A new result beat appears only right after a commit.
	a_valid_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("response valid without a commit");

	// A hit never reports a zero converted address, since zero pairs are refused.
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> (rsp.result_addr != '0))
		else $error("lookup hit with zero converted address");
`endif

endmodule

/* tb/att_scoreboard.sv */
// Scoreboard that predicts every response beat of the address translation table and checks it.
module att_scoreboard
	import att_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	att_req_if   req,
	att_rsp_if   rsp,
	output int   mismatches,
	output int   answers_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] result_addr;
		logic              rejected;
		logic              full_flag;
	} answer_t;

	// Shadow copy of the table; only entries below shadow_fill are ever read.
	logic [ADDR_W-1:0] shadow_keys [TABLE_DEPTH];
	logic [ADDR_W-1:0] shadow_vals [TABLE_DEPTH];
	int                shadow_fill;
	logic              shadow_full;
	answer_t           answer_q [$];
	int                error_count = 0;

	assign mismatches = error_count;

	function automatic answer_t translate(input logic [1:0] action,
		input logic [ADDR_W-1:0] key, input logic [ADDR_W-1:0] mapped);
		answer_t ans;
		ans = '0;
		case (action)
			ACT_LOOKUP: begin
				for (int i = 0; i < shadow_fill; i++) begin
					if (!ans.found && shadow_keys[i] == key) begin
						ans.found       = 1'b1;
						ans.result_addr = shadow_vals[i];
					end
				end
			end
			ACT_INSERT: begin
				if (shadow_fill < TABLE_DEPTH && key != '0 && mapped != '0) begin
					shadow_keys[shadow_fill] = key;
					shadow_vals[shadow_fill] = mapped;
					shadow_fill++;
				end else begin
					shadow_full  = 1'b1;
					ans.rejected = 1'b1;
				end
			end
			ACT_CLEAR: begin
				shadow_fill = 0;
				shadow_full = 1'b0;
			end
			default: ;
		endcase
		ans.full_flag = shadow_full;
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
		input logic [ADDR_W-1:0] want);
		$display("%0t: response error, %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			shadow_full = 1'b0;
			answer_q.delete();
			answers_due = 0;
		end else begin
			// A response can never belong to a request taken at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("beat with nothing outstanding", rsp.result_addr, '0);
				end else begin
					want = answer_q.pop_front();
					if (rsp.found !== want.found)
						report_mismatch("field found", rsp.found, want.found);
					if (rsp.result_addr !== want.result_addr)
						report_mismatch("field result_addr", rsp.result_addr, want.result_addr);
					if (rsp.rejected !== want.rejected)
						report_mismatch("field rejected", rsp.rejected, want.rejected);
					if (rsp.full_flag !== want.full_flag)
						report_mismatch("field full_flag", rsp.full_flag, want.full_flag);
				end
			end
			if (req.valid && req.ready)
				answer_q.push_back(translate(req.action, req.key_addr, req.mapped_addr));
			answers_due = answer_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the address translation table testbench: clock, reset, stimulus and verdict.
module testbench;
	import att_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The action code the block ignores; it has no member in the package enum.
	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam int RANDOM_ITEMS = 750;

	logic clk;
	logic arst_n;

	att_req_if req_ch ();
	att_rsp_if rsp_ch ();

	int mismatches;
	int answers_due;

	// Beats accepted so far on the request channel.
	int beats_sent = 0;
	// When set, neither side idles, so back-to-back beats are exercised too.
	bit calm_phase = 1'b0;
	// Cycles the response side still holds ready low.
	int rsp_hold = 0;
	// Keys this side has inserted since the last clear; used to aim lookups at hits.
	logic [ADDR_W-1:0] live_keys [$];

	address_translation_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	att_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.answers_due (answers_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net: stops a run that hangs and reports it as a failure.
	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	// Response side: after every accepted beat it may hold ready low, unless the phase is calm.
	// Ready changes only at the falling edge; acceptance is judged at the rising edge.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				rsp_hold = calm_phase ? 0 : $urandom_range(0, 4);
		end
	end

	function automatic logic [ADDR_W-1:0] rand_nonzero();
		logic [ADDR_W-1:0] v;
		v = $urandom;
		while (v == '0)
			v = $urandom;
		return v;
	endfunction

	// A key that is probably in the table, or a fresh one if nothing was inserted.
	function automatic logic [ADDR_W-1:0] pick_known();
		if (live_keys.size() == 0)
			return rand_nonzero();
		return live_keys[$urandom_range(0, live_keys.size() - 1)];
	endfunction

	// Drives one request beat and returns once it has been accepted. The idle gap
	// comes first, with valid low; a zero gap keeps valid high across beats.
	task automatic send_req(input logic [1:0] act, input logic [ADDR_W-1:0] key,
		input logic [ADDR_W-1:0] mapped);
		int gap;
		gap = calm_phase ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.key_addr    <= key;
		req_ch.mapped_addr <= mapped;
		do
			@(posedge clk);
		while (!req_ch.ready);
		beats_sent++;
		if (act == ACT_INSERT && key != '0)
			live_keys.push_back(key);
		else if (act == ACT_CLEAR)
			live_keys.delete();
	endtask

	// Stops sending until every outstanding response beat has come back.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (answers_due != 0)
			@(negedge clk);
	endtask

	// One item of an ordinary phase: mostly inserts and lookups aimed at live keys,
	// with refused inserts, the ignored action and an occasional clear mixed in.
	task automatic random_item();
		int r;
		int s;
		logic [ADDR_W-1:0] k;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			k = ($urandom_range(0, 3) == 0) ? pick_known() : rand_nonzero();
			send_req(ACT_INSERT, k, rand_nonzero());
		end else if (r < 78) begin
			s = $urandom_range(0, 9);
			if (s < 7)
				k = pick_known();
			else if (s < 9)
				k = $urandom;
			else
				k = '0;
			send_req(ACT_LOOKUP, k, $urandom);
		end else if (r < 88) begin
			s = $urandom_range(0, 2);
			if (s == 0)
				send_req(ACT_INSERT, '0, rand_nonzero());
			else if (s == 1)
				send_req(ACT_INSERT, rand_nonzero(), '0);
			else
				send_req(ACT_INSERT, '0, '0);
		end else if (r < 95) begin
			send_req(ACT_RESERVED, $urandom, $urandom);
		end else begin
			send_req(ACT_CLEAR, $urandom, $urandom);
		end
	endtask

	// Fills the table to the last entry and past it, so that inserts are refused
	// for lack of room, with lookups reaching deep into the table on the way.
	task automatic fill_phase();
		send_req(ACT_CLEAR, $urandom, $urandom);
		for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
			send_req(ACT_INSERT, rand_nonzero(), rand_nonzero());
			if ($urandom_range(0, 15) == 0)
				send_req(ACT_LOOKUP, pick_known(), $urandom);
		end
		repeat (6)
			send_req(ACT_LOOKUP, pick_known(), $urandom);
		send_req(ACT_LOOKUP, rand_nonzero(), $urandom);
		send_req(ACT_RESERVED, $urandom, $urandom);
		send_req(ACT_CLEAR, $urandom, $urandom);
	endtask

	initial begin
		int start;
		int len;
		bit fill_done;

		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_LOOKUP;
		req_ch.key_addr    = '0;
		req_ch.mapped_addr = '0;
		fill_done          = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Lookups on an empty table, including the zero key.
		send_req(ACT_LOOKUP, '0, '0);
		send_req(ACT_LOOKUP, '1, '1);
		// Inserts refused for a zero address; each sets the sticky flag.
		send_req(ACT_INSERT, '0, 32'h0000_0005);
		send_req(ACT_INSERT, 32'h0000_0005, '0);
		send_req(ACT_INSERT, '0, '0);
		// The ignored action leaves the flag as it stands.
		send_req(ACT_RESERVED, $urandom, $urandom);
		// Clear drops the flag.
		send_req(ACT_CLEAR, '0, '0);
		send_req(ACT_INSERT, '1, '1);
		send_req(ACT_INSERT, 32'h0000_0001, 32'h0000_0001);
		// A duplicate key: lookups must return the first entry inserted.
		send_req(ACT_INSERT, 32'h0000_0001, 32'h0000_0002);
		send_req(ACT_LOOKUP, 32'h0000_0001, '0);
		send_req(ACT_LOOKUP, '1, '0);
		send_req(ACT_LOOKUP, '0, '1);
		send_req(ACT_LOOKUP, 32'h0000_0002, '0);
		send_req(ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		send_req(ACT_LOOKUP, 32'h8000_0000, '0);
		send_req(ACT_RESERVED, '1, '1);
		send_req(ACT_LOOKUP, 32'h7fff_ffff, '0);
		send_req(ACT_CLEAR, '1, '1);
		// Entries are gone after a clear.
		send_req(ACT_LOOKUP, 32'h0000_0001, '0);
		send_req(ACT_INSERT, 32'h1234_5678, '0);
		// The mapped address of a lookup carries no meaning.
		send_req(ACT_LOOKUP, 32'h1234_5678, 32'hdead_beef);
		send_req(ACT_CLEAR, '0, '0);
		// Let every response come home before the random part starts.
		drain();

		// Random part: phases that mostly start from a clear table, one of them
		// filling the table completely.
		start = beats_sent;
		while (beats_sent - start < RANDOM_ITEMS) begin
			calm_phase = ($urandom_range(0, 3) == 0);
			if (!fill_done && beats_sent - start > 150) begin
				fill_phase();
				fill_done = 1'b1;
			end else begin
				if ($urandom_range(0, 4) != 0)
					send_req(ACT_CLEAR, $urandom, $urandom);
				len = $urandom_range(15, 50);
				repeat (len)
					random_item();
			end
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		// Wait for the last response, then give a stray beat time to show up.
		calm_phase = 1'b0;
		drain();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
